[hw/rtl/pwft_pkg.sv]
// Package for the wire-format field tokeniser: beat type, parse modes,
// event kinds, error codes and sizing constants. No dependencies.
`default_nettype none

package pwft_pkg;

    localparam int PWFT_QUEUE_DEPTH = 4;

    localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;
    localparam logic [3:0] FIX64_BYTES      = 4'd8;
    localparam logic [3:0] FIX32_BYTES      = 4'd4;

    // one classified input beat
    typedef struct packed {
        logic [7:0] data;
        logic [6:0] low7;
        logic       cont;
        logic       eom;
    } beat_t;

    typedef enum logic [2:0] {
        MODE_KEY     = 3'd0,
        MODE_VARINT  = 3'd1,
        MODE_FIX64   = 3'd2,
        MODE_FIX32   = 3'd3,
        MODE_LEN     = 3'd4,
        MODE_PAYLOAD = 3'd5,
        MODE_DRAIN   = 3'd6
    } mode_t;

    localparam logic [2:0] EV_VARINT  = 3'd0;
    localparam logic [2:0] EV_FIX64   = 3'd1;
    localparam logic [2:0] EV_FIX32   = 3'd2;
    localparam logic [2:0] EV_HEADER  = 3'd3;
    localparam logic [2:0] EV_PAYLOAD = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;
    localparam logic [1:0] ERR_WTYPE = 2'd3;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_FIX64  = 3'd1;
    localparam logic [2:0] WIRE_LEN    = 3'd2;
    localparam logic [2:0] WIRE_FIX32  = 3'd5;

    // queue handshake toward the back end
    typedef struct packed {
        logic  valid;
        beat_t beat;
    } qhead_t;

endpackage

`default_nettype wire

[hw/rtl/pwft_front.sv]
// Front end: takes input beats, splits off the continuation bit and low
// seven bits, and pushes the beat into the queue. Uses pwft_pkg.
`default_nettype none

module pwft_front (
    input  wire logic          byte_valid,
    output logic               byte_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_message,
    input  wire logic          q_full,
    output logic               q_push,
    output pwft_pkg::beat_t    q_beat
);
    import pwft_pkg::*;

    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        q_beat.data = data_byte;
        q_beat.low7 = data_byte[6:0];
        q_beat.cont = data_byte[7];
        q_beat.eom  = end_of_message;
    end

endmodule

`default_nettype wire

[hw/rtl/pwft_queue.sv]
// Short FIFO of classified beats between front and back end.
// Uses pwft_pkg for the beat and head types.
`default_nettype none

module pwft_queue #(
    parameter int DEPTH = pwft_pkg::PWFT_QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire pwft_pkg::beat_t push_beat,
    output logic                 full,
    input  wire logic            pop,
    output pwft_pkg::qhead_t     head
);
    import pwft_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    beat_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_beat;
        end
    end

    always_comb
    begin
        head.valid = (count_reg != '0);
        head.beat  = mem_reg[rd_ptr_reg];
    end

endmodule

`default_nettype wire

[hw/rtl/pwft_back.sv]
// Back end: wire-format parser state machine and the output register.
// Takes one queued beat per cycle unless a held result stalls it. Uses pwft_pkg.
`default_nettype none

module pwft_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pwft_pkg::qhead_t head,
    output logic                  pop,
    output logic                  event_valid,
    input  wire logic             event_stall,
    output logic [2:0]            event_kind,
    output logic [28:0]           field_number,
    output logic [63:0]           field_value,
    output logic [1:0]            error_code,
    output logic                  last_of_message
);
    import pwft_pkg::*;

    mode_t        mode_reg, mode_next;
    logic [63:0]  acc_reg, acc_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [28:0]  fnum_reg, fnum_next;
    logic [63:0]  rem_reg, rem_next;

    logic         out_valid_reg;
    logic [2:0]   kind_reg;
    logic [28:0]  fnum_out_reg;
    logic [63:0]  value_reg;
    logic [1:0]   err_reg;
    logic         last_reg;

    beat_t        b;
    logic [3:0]   cnt_inc;
    logic [6:0]   sh7;
    logic [63:0]  acc_var, acc_fix;
    logic [28:0]  key_fnum;
    logic [2:0]   key_wt;
    logic         wt_ok;
    logic         fix_done;
    logic [63:0]  rem_dec;
    logic         rem_gt1;

    logic [1:0]   step_err;
    logic         step_emit;
    logic [2:0]   step_kind;
    logic [63:0]  step_value;
    logic [28:0]  step_fnum;

    assign b   = head.beat;
    assign pop = head.valid && (!out_valid_reg || !event_stall);

    // datapath terms
    assign cnt_inc  = cnt_reg + 4'd1;
    assign sh7      = 7'({3'b000, cnt_reg} * 7'd7);
    assign acc_var  = acc_reg | ((cnt_reg < MAX_VARINT_BYTES) ? (64'(b.low7) << sh7) : 64'd0);
    assign acc_fix  = acc_reg | ((cnt_reg < FIX64_BYTES) ?
                      (64'(b.data) << {cnt_reg[2:0], 3'b000}) : 64'd0);
    assign key_fnum = acc_var[31:3];
    assign key_wt   = acc_var[2:0];
    assign wt_ok    = (key_wt == WIRE_VARINT) || (key_wt == WIRE_FIX64) ||
                      (key_wt == WIRE_LEN) || (key_wt == WIRE_FIX32);
    assign fix_done = cnt_inc >= ((mode_reg == MODE_FIX64) ? FIX64_BYTES : FIX32_BYTES);
    assign rem_dec  = (rem_reg != 64'd0) ? rem_reg - 64'd1 : rem_reg;
    assign rem_gt1  = rem_reg > 64'd1;

    // error check and result selection for the current beat
    always_comb
    begin
        step_err   = ERR_NONE;
        step_emit  = 1'b0;
        step_kind  = EV_ERROR;
        step_value = 64'd0;
        step_fnum  = fnum_reg;
        case (mode_reg)
            MODE_KEY, MODE_VARINT, MODE_LEN:
            begin
                if (mode_reg == MODE_KEY)
                begin
                    step_fnum = b.cont ? 29'd0 : key_fnum;
                end
                if (b.cont)
                begin
                    if (cnt_inc >= MAX_VARINT_BYTES)
                    begin
                        step_err = ERR_LONG;
                    end
                    else if (b.eom)
                    begin
                        step_err = ERR_TRUNC;
                    end
                end
                else if (mode_reg == MODE_KEY)
                begin
                    if (!wt_ok)
                    begin
                        step_err = ERR_WTYPE;
                    end
                    else if (b.eom)
                    begin
                        step_err = ERR_TRUNC;
                    end
                end
                else if (mode_reg == MODE_VARINT)
                begin
                    step_emit  = 1'b1;
                    step_kind  = EV_VARINT;
                    step_value = acc_var;
                end
                else if ((acc_var != 64'd0) && b.eom)
                begin
                    step_err = ERR_TRUNC;
                end
                else
                begin
                    step_emit  = 1'b1;
                    step_kind  = EV_HEADER;
                    step_value = acc_var;
                end
            end
            MODE_FIX64, MODE_FIX32:
            begin
                if (fix_done)
                begin
                    step_emit  = 1'b1;
                    step_kind  = (mode_reg == MODE_FIX64) ? EV_FIX64 : EV_FIX32;
                    step_value = acc_fix;
                end
                else if (b.eom)
                begin
                    step_err = ERR_TRUNC;
                end
            end
            MODE_PAYLOAD:
            begin
                if (rem_gt1 && b.eom)
                begin
                    step_err = ERR_TRUNC;
                end
                else
                begin
                    step_emit  = 1'b1;
                    step_kind  = EV_PAYLOAD;
                    step_value = 64'(b.data);
                end
            end
            default:
            begin
                step_err = ERR_NONE;
            end
        endcase
        if (step_err != ERR_NONE)
        begin
            step_emit  = 1'b1;
            step_kind  = EV_ERROR;
            step_value = 64'd0;
        end
    end

    // next parse mode
    always_comb
    begin
        mode_next = mode_reg;
        if (pop)
        begin
            if (step_err != ERR_NONE)
            begin
                mode_next = b.eom ? MODE_KEY : MODE_DRAIN;
            end
            else
            begin
                case (mode_reg)
                    MODE_KEY:
                    begin
                        if (!b.cont)
                        begin
                            case (key_wt)
                                WIRE_VARINT: mode_next = MODE_VARINT;
                                WIRE_FIX64:  mode_next = MODE_FIX64;
                                WIRE_LEN:    mode_next = MODE_LEN;
                                WIRE_FIX32:  mode_next = MODE_FIX32;
                                default:     mode_next = MODE_DRAIN;
                            endcase
                        end
                    end
                    MODE_VARINT:
                    begin
                        mode_next = b.cont ? MODE_VARINT : MODE_KEY;
                    end
                    MODE_LEN:
                    begin
                        if (!b.cont)
                        begin
                            mode_next = (acc_var == 64'd0) ? MODE_KEY : MODE_PAYLOAD;
                        end
                    end
                    MODE_FIX64, MODE_FIX32:
                    begin
                        if (fix_done)
                        begin
                            mode_next = MODE_KEY;
                        end
                    end
                    MODE_PAYLOAD:
                    begin
                        if (rem_dec == 64'd0)
                        begin
                            mode_next = MODE_KEY;
                        end
                    end
                    default:
                    begin
                        mode_next = b.eom ? MODE_KEY : MODE_DRAIN;
                    end
                endcase
            end
        end
    end

    // item registers
    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        fnum_next = fnum_reg;
        rem_next  = rem_reg;
        if (pop)
        begin
            if ((mode_reg == MODE_KEY) && !b.cont)
            begin
                fnum_next = key_fnum;
            end
            if (step_err != ERR_NONE)
            begin
                acc_next = 64'd0;
                cnt_next = 4'd0;
                rem_next = 64'd0;
            end
            else
            begin
                case (mode_reg)
                    MODE_KEY, MODE_VARINT, MODE_LEN:
                    begin
                        if (b.cont)
                        begin
                            acc_next = acc_var;
                            cnt_next = cnt_inc;
                        end
                        else
                        begin
                            acc_next = 64'd0;
                            cnt_next = 4'd0;
                            if (mode_reg == MODE_LEN)
                            begin
                                rem_next = acc_var;
                            end
                        end
                    end
                    MODE_FIX64, MODE_FIX32:
                    begin
                        if (fix_done)
                        begin
                            acc_next = 64'd0;
                            cnt_next = 4'd0;
                            rem_next = 64'd0;
                        end
                        else
                        begin
                            acc_next = acc_fix;
                            cnt_next = cnt_inc;
                        end
                    end
                    MODE_PAYLOAD:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 64'd0)
                        begin
                            acc_next = 64'd0;
                            cnt_next = 4'd0;
                        end
                    end
                    default:
                    begin
                        if (b.eom)
                        begin
                            acc_next = 64'd0;
                            cnt_next = 4'd0;
                            rem_next = 64'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_KEY;
            acc_reg       <= 64'd0;
            cnt_reg       <= 4'd0;
            fnum_reg      <= 29'd0;
            rem_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            fnum_reg <= fnum_next;
            rem_reg  <= rem_next;
            if (pop)
            begin
                out_valid_reg <= step_emit;
            end
            else if (!event_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && step_emit)
        begin
            kind_reg     <= step_kind;
            fnum_out_reg <= step_fnum;
            value_reg    <= step_value;
            err_reg      <= step_err;
            last_reg     <= b.eom;
        end
    end

    assign event_valid     = out_valid_reg;
    assign event_kind      = kind_reg;
    assign field_number    = fnum_out_reg;
    assign field_value     = value_reg;
    assign error_code      = err_reg;
    assign last_of_message = last_reg;

endmodule

`default_nettype wire

[hw/rtl/protobuf_wire_field_tokenizer.sv]
// Top level of the wire-format field tokeniser.
// Depends on pwft_pkg, pwft_front, pwft_queue and pwft_back.
`default_nettype none

// Channel   Valid         Stall         Payload
// -------   -----------   -----------   ------------------------------------------
// input     byte_valid    byte_stall    data_byte, end_of_message
// result    event_valid   event_stall   event_kind, field_number, field_value,
//                                       error_code, last_of_message
//
// One byte per clock sustained while results are not stalled: each queued beat
// is at most one shift-or into the accumulator or one 64-bit decrement of the
// payload count. A byte is queued, then its result registered in the back end.
// Reset clears queue pointers, parse mode, item registers and result valid.
// A held result stops the back end; the queue (QUEUE_DEPTH beats) keeps taking
// input until it fills, then byte_stall rises.

module protobuf_wire_field_tokenizer #(
    parameter int QUEUE_DEPTH = pwft_pkg::PWFT_QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire logic [7:0]   data_byte,
    input  wire logic         end_of_message,
    output logic              event_valid,
    input  wire logic         event_stall,
    output logic [2:0]        event_kind,
    output logic [28:0]       field_number,
    output logic [63:0]       field_value,
    output logic [1:0]        error_code,
    output logic              last_of_message
);
    import pwft_pkg::*;

    logic    q_full;
    logic    q_push;
    beat_t   q_beat;
    logic    q_pop;
    qhead_t  q_head;

    // front: classify and enqueue
    pwft_front u_front (
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_beat         (q_beat)
    );

    // decoupling queue
    pwft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_beat (q_beat),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    // back: parser and result register
    pwft_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .pop             (q_pop),
        .event_valid     (event_valid),
        .event_stall     (event_stall),
        .event_kind      (event_kind),
        .field_number    (field_number),
        .field_value     (field_value),
        .error_code      (error_code),
        .last_of_message (last_of_message)
    );

endmodule

`default_nettype wire

[dv/tokenizer_checker.sv]
// Scoreboard for the wire-format field tokeniser: predicts each result beat from
// the accepted input bytes and compares it field by field with the block's output.
// Depends on pwft_pkg for parse modes, event kinds, error codes and wire types.
module tokenizer_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_message,
    input  wire logic        event_valid,
    input  wire logic        event_stall,
    input  wire logic [2:0]  event_kind,
    input  wire logic [28:0] field_number,
    input  wire logic [63:0] field_value,
    input  wire logic [1:0]  error_code,
    input  wire logic        last_of_message,
    output logic [31:0]      mismatch_count,
    output logic [31:0]      events_owed,
    output logic [31:0]      events_checked
);
    import pwft_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [28:0] fnum;
        logic [63:0] value;
        logic [1:0]  err;
        logic        last;
    } field_event_t;

    field_event_t expected_events[$];

    // predictor state
    mode_t       mode;
    logic [63:0] acc;
    logic [3:0]  nbytes;
    logic [28:0] cur_fnum;
    logic [2:0]  cur_wt;
    logic [63:0] payload_owed;

    task automatic queue_event(input logic [2:0] kind, input logic [28:0] fnum,
                               input logic [63:0] value, input logic [1:0] err,
                               input logic last);
        field_event_t e;
        e.kind  = kind;
        e.fnum  = fnum;
        e.value = value;
        e.err   = err;
        e.last  = last;
        expected_events.push_back(e);
    endtask

    task automatic flag_error(input logic [28:0] fnum, input logic [1:0] err,
                              input logic eom);
        acc          = '0;
        nbytes       = '0;
        payload_owed = '0;
        mode         = eom ? MODE_KEY : MODE_DRAIN;
        queue_event(EV_ERROR, fnum, 64'd0, err, eom);
    endtask

    task automatic tokenize_byte(input logic [7:0] b, input logic eom);
        logic [28:0] fn;
        logic [63:0] v;
        logic [3:0]  need;
        int          sh;
        fn = (mode == MODE_KEY) ? 29'd0 : cur_fnum;
        case (mode)
            MODE_KEY, MODE_VARINT, MODE_LEN:
            begin
                if (nbytes < MAX_VARINT_BYTES)
                begin
                    sh = 7 * int'(nbytes);
                    if (sh < 64)
                        acc |= 64'(b[6:0]) << sh;
                end
                nbytes = nbytes + 4'd1;
                if (b[7])
                begin
                    if (nbytes >= MAX_VARINT_BYTES)
                        flag_error(fn, ERR_LONG, eom);
                    else if (eom)
                        flag_error(fn, ERR_TRUNC, eom);
                end
                else
                begin
                    v      = acc;
                    acc    = '0;
                    nbytes = '0;
                    if (mode == MODE_KEY)
                    begin
                        cur_fnum = v[31:3];
                        cur_wt   = v[2:0];
                        case (cur_wt)
                            WIRE_VARINT: mode = MODE_VARINT;
                            WIRE_FIX64:  mode = MODE_FIX64;
                            WIRE_LEN:    mode = MODE_LEN;
                            WIRE_FIX32:  mode = MODE_FIX32;
                            default:     mode = MODE_DRAIN;
                        endcase
                        if (mode == MODE_DRAIN)
                            flag_error(cur_fnum, ERR_WTYPE, eom);
                        else if (eom)
                            flag_error(cur_fnum, ERR_TRUNC, eom);
                    end
                    else if (mode == MODE_VARINT)
                    begin
                        mode = MODE_KEY;
                        queue_event(EV_VARINT, fn, v, ERR_NONE, eom);
                    end
                    else if (v == 64'd0)
                    begin
                        mode = MODE_KEY;
                        queue_event(EV_HEADER, fn, 64'd0, ERR_NONE, eom);
                    end
                    else if (eom)
                        flag_error(fn, ERR_TRUNC, eom);
                    else
                    begin
                        payload_owed = v;
                        mode         = MODE_PAYLOAD;
                        queue_event(EV_HEADER, fn, v, ERR_NONE, 1'b0);
                    end
                end
            end
            MODE_FIX64, MODE_FIX32:
            begin
                need = (mode == MODE_FIX64) ? FIX64_BYTES : FIX32_BYTES;
                if (nbytes < FIX64_BYTES)
                    acc |= 64'(b) << (8 * int'(nbytes));
                nbytes = nbytes + 4'd1;
                if (nbytes >= need)
                begin
                    queue_event((mode == MODE_FIX64) ? EV_FIX64 : EV_FIX32, fn, acc,
                                ERR_NONE, eom);
                    acc          = '0;
                    nbytes       = '0;
                    payload_owed = '0;
                    mode         = MODE_KEY;
                end
                else if (eom)
                    flag_error(fn, ERR_TRUNC, eom);
            end
            MODE_PAYLOAD:
            begin
                if (payload_owed > 64'd1 && eom)
                    flag_error(fn, ERR_TRUNC, eom);
                else
                begin
                    if (payload_owed > 64'd0)
                        payload_owed = payload_owed - 64'd1;
                    if (payload_owed == 64'd0)
                    begin
                        acc    = '0;
                        nbytes = '0;
                        mode   = MODE_KEY;
                    end
                    queue_event(EV_PAYLOAD, fn, 64'(b), ERR_NONE, eom);
                end
            end
            default:
            begin
                // draining after an error: silent until the end of the message
                if (eom)
                begin
                    acc          = '0;
                    nbytes       = '0;
                    payload_owed = '0;
                    mode         = MODE_KEY;
                end
                else
                    mode = MODE_DRAIN;
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    task automatic check_event();
        field_event_t want;
        if (expected_events.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: result beat with nothing expected: kind %0d field %0d value 0x%0h",
                     $time, event_kind, field_number, field_value);
        end
        else
        begin
            want = expected_events.pop_front();
            events_checked++;
            check_field("event_kind", 64'(want.kind), 64'(event_kind));
            check_field("field_number", 64'(want.fnum), 64'(field_number));
            check_field("field_value", want.value, field_value);
            check_field("error_code", 64'(want.err), 64'(error_code));
            check_field("last_of_message", 64'(want.last), 64'(last_of_message));
        end
    endtask

    // result side is compared before the new byte is predicted: the block
    // cannot answer a byte in the cycle it takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode           = MODE_KEY;
            acc            = '0;
            nbytes         = '0;
            cur_fnum       = '0;
            cur_wt         = '0;
            payload_owed   = '0;
            expected_events.delete();
            mismatch_count = '0;
            events_owed    = '0;
            events_checked = '0;
        end
        else
        begin
            if (event_valid && !event_stall)
                check_event();
            if (byte_valid && !byte_stall)
                tokenize_byte(data_byte, end_of_message);
            events_owed = expected_events.size();
        end
    end

endmodule

[dv/tb_protobuf_wire_field_tokenizer.sv]
// Testbench top for the wire-format field tokeniser: clock, reset, byte stimulus,
// result-side stalls, watchdog and verdict.
// Depends on pwft_pkg, protobuf_wire_field_tokenizer and tokenizer_checker.
module tb_protobuf_wire_field_tokenizer;
    import pwft_pkg::*;

    // wire types the block must refuse (group start/end and the two unused codes)
    localparam logic [2:0] WIRE_GROUP_START = 3'd3;
    localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
    localparam logic [2:0] WIRE_RESV6       = 3'd6;
    localparam logic [2:0] WIRE_RESV7       = 3'd7;
    localparam logic [7:0] CONT_BIT         = 8'h80;

    localparam int RANDOM_UNTIL = 400;   // directed part is about 30 bytes
    localparam int HOLD_AT      = 150;   // byte count at which the sink holds off
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat moving on either side
    localparam int TAIL_CYCLES  = 10;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        byte_valid     = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte      = 8'd0;
    logic        end_of_message = 1'b0;
    logic        event_valid;
    logic        event_stall    = 1'b0;
    logic [2:0]  event_kind;
    logic [28:0] field_number;
    logic [63:0] field_value;
    logic [1:0]  error_code;
    logic        last_of_message;

    logic [31:0] mismatch_count;
    logic [31:0] events_owed;
    logic [31:0] events_checked;

    int          bytes_sent    = 0;
    int          messages_sent = 0;
    bit          hold_done     = 1'b0;
    logic [7:0]  msg[$];         // message under construction

    protobuf_wire_field_tokenizer DUT (.*);

    tokenizer_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Both sides run flat out over this window of bytes, no random idling.
    function automatic bit calm_stretch();
        return bytes_sent >= 220 && bytes_sent < 320;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. One beat per call; values change on the falling edge and
    // the handshake is judged on the rising edge, so sampling never races
    // the block. byte_valid gets at most one update per falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        if (!calm_stretch() && $urandom_range(0, 99) < 6)
        begin
            byte_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
        byte_valid     <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send the built message, flagging its last byte as end of message.
    task automatic send_message();
        int i;
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
        msg.delete();
        messages_sent++;
    endtask

    // Base-128 encoding, low group first. A nonzero pad adds redundant
    // continuation groups (still legal up to ten bytes). On a tenth byte the
    // bits above bit 63 are sometimes filled with junk, which must be dropped.
    task automatic put_varint(input logic [63:0] v, input int pad);
        int         groups;
        int         i;
        logic [7:0] b;
        groups = 1;
        while (groups < 10 && (v >> (7 * groups)) != 64'd0)
            groups++;
        groups = (groups + pad > 10) ? 10 : groups + pad;
        for (i = 0; i < groups; i++)
        begin
            b = {1'b0, 7'(v >> (7 * i))};
            if (i < groups - 1)
                b = b | CONT_BIT;
            else if (i == 9 && $urandom_range(0, 1) == 1)
                b[6:1] = 6'($urandom);
            msg.push_back(b);
        end
    endtask

    task automatic put_tag(input logic [28:0] fnum, input logic [2:0] wt);
        put_varint({32'd0, fnum, wt}, 0);
    endtask

    function automatic int pad_count();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            2:       return r;
            default: return r >> $urandom_range(0, 63);
        endcase
    endfunction

    // Random key: mostly small field numbers, now and then the largest one or
    // a random one, and now and then junk in key bits above 31 (dropped).
    task automatic put_key(input logic [2:0] wt);
        logic [63:0] key;
        logic [28:0] fnum;
        case ($urandom_range(0, 9))
            0:       fnum = '1;
            1:       fnum = 29'($urandom);
            default: fnum = 29'($urandom_range(1, 15));
        endcase
        key = {32'd0, fnum, wt};
        if ($urandom_range(0, 9) == 0)
            key[63:32] = $urandom;
        put_varint(key, pad_count());
    endtask

    task automatic put_good_field();
        int n;
        int i;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                put_key(WIRE_VARINT);
                put_varint(rand_value(), pad_count());
            end
            3, 4:
            begin
                put_key(WIRE_FIX64);
                repeat (8) msg.push_back(8'($urandom));
            end
            5, 6:
            begin
                put_key(WIRE_FIX32);
                repeat (4) msg.push_back(8'($urandom));
            end
            default:
            begin
                // short payloads keep the run brisk; a few longer ones
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24)
                                                : $urandom_range(0, 5);
                put_key(WIRE_LEN);
                put_varint(64'(n), pad_count());
                for (i = 0; i < n; i++)
                    msg.push_back(8'($urandom));
            end
        endcase
    endtask

    function automatic logic [2:0] bad_wire_type();
        case ($urandom_range(0, 3))
            0:       return WIRE_GROUP_START;
            1:       return WIRE_GROUP_END;
            2:       return WIRE_RESV6;
            default: return WIRE_RESV7;
        endcase
    endfunction

    // A malformed field. Bad wire types and overlong varints leave the rest
    // of the message to be drained; a cut field ends the message there.
    task automatic put_bad_field(output bit cut);
        int start;
        int keep;
        cut = 1'b0;
        case ($urandom_range(0, 2))
            0:
                put_key(bad_wire_type());
            1:
            begin
                // overlong varint in the key, a value or a length
                case ($urandom_range(0, 2))
                    0:       ;
                    1:       put_key(WIRE_VARINT);
                    default: put_key(WIRE_LEN);
                endcase
                repeat ($urandom_range(10, 12))
                    msg.push_back(8'($urandom) | CONT_BIT);
            end
            default:
            begin
                // truncation: keep a strict prefix of a well-formed field
                start = msg.size();
                put_good_field();
                keep = $urandom_range(1, msg.size() - start - 1);
                while (msg.size() > start + keep)
                    void'(msg.pop_back());
                cut = 1'b1;
            end
        endcase
    endtask

    // Mostly well-formed messages of one to four fields with random content,
    // about a fifth with one malformed field, and a little raw noise.
    task automatic send_random_message();
        int nfields;
        int bad_at;
        int f;
        bit cut;
        cut = 1'b0;
        if ($urandom_range(0, 99) < 5)
        begin
            repeat ($urandom_range(1, 6))
                msg.push_back(8'($urandom));
        end
        else
        begin
            nfields = $urandom_range(1, 4);
            bad_at  = ($urandom_range(0, 99) < 20) ? $urandom_range(0, nfields - 1) : -1;
            for (f = 0; f < nfields && !cut; f++)
            begin
                if (f == bad_at)
                    put_bad_field(cut);
                else
                    put_good_field();
            end
        end
        send_message();
    endtask

    // ------------------------------------------------------------------
    // Result side. Random stalls at about 6 %, none in the calm window, and
    // one long hold-off so the internal queue fills and byte_stall rises
    // while the sender keeps offering bytes.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        forever
        begin
            @(negedge clk);
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                event_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            event_stall <= !calm_stretch() && ($urandom_range(0, 99) < 6);
        end
    end

    // Watchdog: gives up once no beat has moved on either channel for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (event_valid && !event_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // varint zero, all-ones fixed64, fixed32; message ends on a complete field
        put_tag(29'd1, WIRE_VARINT);
        msg.push_back(8'h00);
        put_tag(29'd2, WIRE_FIX64);
        repeat (8) msg.push_back(8'hFF);
        put_tag(29'd3, WIRE_FIX32);
        msg.push_back(8'h01);
        msg.push_back(8'h02);
        msg.push_back(8'h03);
        msg.push_back(8'h04);
        send_message();
        // zero length: header only, and it ends the message
        put_tag(29'd4, WIRE_LEN);
        msg.push_back(8'h00);
        send_message();
        // header then two payload bytes, the last one ending the message
        put_tag(29'd5, WIRE_LEN);
        msg.push_back(8'h02);
        msg.push_back(8'hAB);
        msg.push_back(8'h54);
        send_message();
        // unsupported wire type mid-message, then the rest is drained silently
        put_tag(29'd6, WIRE_GROUP_START);
        msg.push_back(8'h55);
        msg.push_back(8'h77);
        send_message();
        // nonzero length whose header ends the message
        put_tag(29'd7, WIRE_LEN);
        msg.push_back(8'h03);
        send_message();
        // bad wire type on the final byte wins over truncation
        put_tag(29'd8, WIRE_GROUP_END);
        send_message();
        // message ends inside a key: truncation with field number zero
        msg.push_back(CONT_BIT);
        send_message();

        while (bytes_sent < RANDOM_UNTIL)
            send_random_message();
        byte_valid <= 1'b0;

        while (events_owed != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d bytes in %0d messages; %0d result beats checked.",
                 bytes_sent, messages_sent, events_checked);
        $display("Mixed varint, fixed and length fields with bad keys, cut and overlong %s",
                 "fields, random stalls and one long result hold-off.");
        if (mismatch_count == 0 && events_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
